// ----- hdl/fsmatch_pkg.sv -----
// ----------------------------------------------------------------------------
// fsmatch_pkg
// Shared types and constants for the first substring match block.
// ----------------------------------------------------------------------------
package fsmatch_pkg;

    localparam int PAT_BYTES = 16;
    localparam int PLEN_W    = 5;
    localparam int CAP_W     = 13;
    localparam int POS_W     = 12;
    localparam int WORD_W    = 64;

    typedef enum logic [1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2,
        REG_TEXT_CAPACITY  = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_SEARCHED      = 2'd0,
        ST_EMPTY_TEXT    = 2'd1,
        ST_EMPTY_PATTERN = 2'd2,
        ST_UNTERMINATED  = 2'd3
    } status_t;

    typedef struct packed {
        logic [PAT_BYTES*8-1:0] pattern;
        logic [PLEN_W-1:0]      plen;
        logic [CAP_W-1:0]       cap;
    } cfg_t;

endpackage

// ----- hdl/first_substring_match.sv -----
// ----------------------------------------------------------------------------
// first_substring_match
// Streams text bytes through a window and reports the first pattern match
// when the text ends, or an unterminated error when capacity is reached.
// ----------------------------------------------------------------------------
// Each byte enters the input register; its result goes to the result register.
// Throughput: one byte per cycle via the compare stage unless a result stalls.
// An input register and a result register separate the two channels.
// Reset clears the configuration to its defaults and starts a new text.
// ----------------------------------------------------------------------------
module first_substring_match
    import fsmatch_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int MAX_TEXT    = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [WORD_W-1:0] cfg_data,
    input  logic              text_valid,
    output logic              text_stall,
    input  logic [7:0]        text_byte,
    output logic              result_valid,
    input  logic              result_stall,
    output logic              found,
    output logic [POS_W-1:0]  match_position,
    output logic [1:0]        status
);

    localparam int CNT_W = $clog2(MAX_TEXT + 1);

    cfg_t cfg;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic [7:0]       win_reg  [MAX_PATTERN];
    logic [7:0]       win_next [MAX_PATTERN];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_inc;
    logic             seen_reg;
    logic [POS_W-1:0] start_reg;

    logic             out_valid_reg;
    logic             found_reg;
    logic [POS_W-1:0] pos_reg;
    status_t          status_reg;

    logic             hit;
    logic             is_nul;
    logic             cap_hit;
    logic             plen_ok;
    logic             emit;
    logic             advance;
    logic             found_next;
    logic [POS_W-1:0] pos_next;
    status_t          status_next;

    assign cfg_ready = 1'b1;

    fsmatch_cfg #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    always_comb
    begin
        win_next[0] = in_byte_reg;
        for (int k = 1; k < MAX_PATTERN; k++)
            win_next[k] = win_reg[k-1];
    end

    fsmatch_window_cmp #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cmp (
        .window  (win_next),
        .pattern (cfg.pattern),
        .plen    (cfg.plen),
        .hit     (hit)
    );

    assign count_inc = count_reg + CNT_W'(1);
    assign is_nul    = (in_byte_reg == 8'd0);
    assign cap_hit   = !is_nul && (CAP_W'(count_inc) >= cfg.cap);
    assign plen_ok   = (cfg.plen != '0) && (CAP_W'(count_inc) >= CAP_W'(cfg.plen));
    assign emit      = is_nul || cap_hit;
    assign advance   = in_valid_reg && (!emit || !out_valid_reg || !result_stall);
    assign text_stall = in_valid_reg && !advance;

    always_comb
    begin
        found_next  = 1'b0;
        pos_next    = '0;
        status_next = ST_SEARCHED;
        if (is_nul)
        begin
            if (count_reg == '0)
                status_next = ST_EMPTY_TEXT;
            else if (cfg.plen == '0)
                status_next = ST_EMPTY_PATTERN;
            else
            begin
                found_next = seen_reg;
                pos_next   = seen_reg ? start_reg : '0;
            end
        end
        else
            status_next = ST_UNTERMINATED;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!text_stall)
            in_valid_reg <= text_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!text_stall && text_valid)
            in_byte_reg <= text_byte;
    end

    always_ff @(posedge clk)
    begin
        if (advance && !is_nul)
            win_reg <= win_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            seen_reg  <= 1'b0;
        end
        else if (advance)
        begin
            if (emit)
            begin
                count_reg <= '0;
                seen_reg  <= 1'b0;
            end
            else
            begin
                count_reg <= count_inc;
                if (plen_ok && !seen_reg && hit)
                    seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && !emit && plen_ok && !seen_reg && hit)
            start_reg <= POS_W'(CAP_W'(count_inc) - CAP_W'(cfg.plen));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && emit)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            found_reg  <= found_next;
            pos_reg    <= pos_next;
            status_reg <= status_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign found          = found_reg;
    assign match_position = pos_reg;
    assign status         = status_reg;

    a_found_only_searched: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && found |-> status == ST_SEARCHED)
        else $error("match reported with a non-search status");

    a_no_position_without_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> match_position == '0)
        else $error("nonzero position without a match");

    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> result_valid && result_stall)
        else $error("input stalled while the result side is free");

    a_seen_needs_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> count_reg != '0)
        else $error("match recorded in an empty text");

endmodule

// ----- hdl/fsmatch_cfg.sv -----
// ----------------------------------------------------------------------------
// fsmatch_cfg
// Configuration registers with clamped effective pattern length and capacity.
// ----------------------------------------------------------------------------
module fsmatch_cfg
    import fsmatch_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int MAX_TEXT    = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [1:0]        wr_index,
    input  logic [WORD_W-1:0] wr_data,
    output cfg_t              cfg
);

    logic [WORD_W-1:0] pat_low_reg;
    logic [WORD_W-1:0] pat_high_reg;
    logic [PLEN_W-1:0] plen_reg;
    logic [CAP_W-1:0]  cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            plen_reg     <= '0;
            cap_reg      <= CAP_W'(4096);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_PATTERN_LOW:    pat_low_reg  <= wr_data;
                REG_PATTERN_HIGH:   pat_high_reg <= wr_data;
                REG_PATTERN_LENGTH: plen_reg     <= wr_data[PLEN_W-1:0];
                REG_TEXT_CAPACITY:  cap_reg      <= wr_data[CAP_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        cfg.pattern = {pat_high_reg, pat_low_reg};
        if (plen_reg > PLEN_W'(MAX_PATTERN))
            cfg.plen = PLEN_W'(MAX_PATTERN);
        else
            cfg.plen = plen_reg;
        if (cap_reg == '0)
            cfg.cap = CAP_W'(1);
        else if (cap_reg > CAP_W'(MAX_TEXT))
            cfg.cap = CAP_W'(MAX_TEXT);
        else
            cfg.cap = cap_reg;
    end

endmodule

// ----- hdl/fsmatch_window_cmp.sv -----
// ----------------------------------------------------------------------------
// fsmatch_window_cmp
// Parallel compare of the newest window bytes against the pattern.
// ----------------------------------------------------------------------------
module fsmatch_window_cmp
    import fsmatch_pkg::*;
#(
    parameter int MAX_PATTERN = 16
)
(
    input  logic [7:0]             window [MAX_PATTERN],
    input  logic [PAT_BYTES*8-1:0] pattern,
    input  logic [PLEN_W-1:0]      plen,
    output logic                   hit
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [MAX_PATTERN-1:0] eq;
    logic [PLEN_W-1:0]      diff [MAX_PATTERN];

    // Pattern byte j lines up with the byte received plen-1-j items ago.
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            diff[j] = plen - PLEN_W'(j) - PLEN_W'(1);
            if (PLEN_W'(j) < plen)
                eq[j] = (pattern[8*j +: 8] == window[diff[j][IDX_W-1:0]]);
            else
                eq[j] = 1'b1;
        end
    end

    assign hit = &eq;

endmodule

// ----- verif/first_substring_match_tb.sv -----
// ----------------------------------------------------------------------------
// first_substring_match_tb
// Streams byte texts into the substring search block and checks each search
// report against a cycle-free predictor that tracks the byte window, the
// first match and the text length under the current pattern and capacity.
// Directed texts cover empty text, empty pattern, first-versus-last match,
// short text, NUL inside the pattern and capacity limits; random phases vary
// the configuration, sender gaps and receiver stalls; further texts add a long
// receiver hold-off and a capacity above the maximum.
// ----------------------------------------------------------------------------
module first_substring_match_tb;
    import fsmatch_pkg::*;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
        status_t          st;
    } search_report_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = REG_PATTERN_LOW;
    logic [WORD_W-1:0] cfg_data = '0;
    logic              text_valid = 1'b0;
    logic              text_stall;
    logic [7:0]        text_byte = 8'h00;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic              found;
    logic [POS_W-1:0]  match_position;
    logic [1:0]        status;

    logic [7:0]        text_to_send[$];
    search_report_t    search_reports[$];
    int                bytes_queued = 0;
    int                mismatches = 0;
    int                gap_pct = 0;
    int                stall_pct = 0;
    logic              hold_results = 1'b0;
    logic [7:0]        letters[3];

    logic [WORD_W-1:0] pat_word_lo = '0;
    logic [WORD_W-1:0] pat_word_hi = '0;
    logic [PLEN_W-1:0] pat_len_reg = '0;
    logic [CAP_W-1:0]  cap_reg = 13'd4096;

    logic [7:0]        window_bytes[PAT_BYTES];
    int                text_len = 0;
    logic              hit_seen = 1'b0;
    logic [POS_W-1:0]  hit_start = '0;

    first_substring_match dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .text_valid     (text_valid),
        .text_stall     (text_stall),
        .text_byte      (text_byte),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .found          (found),
        .match_position (match_position),
        .status         (status)
    );

    always #1 clk = ~clk;

    function automatic logic [7:0] pattern_byte(input int j);
        logic [2*WORD_W-1:0] all_bytes;
        all_bytes = {pat_word_hi, pat_word_lo};
        return all_bytes[8*j +: 8];
    endfunction

    function automatic int active_plen();
        return (pat_len_reg > PAT_BYTES) ? PAT_BYTES : int'(pat_len_reg);
    endfunction

    task automatic clear_text();
        for (int k = 0; k < PAT_BYTES; k++)
        begin
            window_bytes[k] = 8'h00;
        end
        text_len  = 0;
        hit_seen  = 1'b0;
        hit_start = '0;
    endtask

    task automatic scan_byte(input logic [7:0] b);
        int             plen;
        int             cap;
        logic           ok;
        search_report_t r;
        plen = active_plen();
        cap  = (cap_reg == 0) ? 1 : ((cap_reg > 4096) ? 4096 : int'(cap_reg));
        r.found = 1'b0;
        r.pos   = '0;
        r.st    = ST_SEARCHED;
        if (b == 8'h00)
        begin
            if (text_len == 0)
                r.st = ST_EMPTY_TEXT;
            else if (plen == 0)
                r.st = ST_EMPTY_PATTERN;
            else
            begin
                r.found = hit_seen;
                r.pos   = hit_seen ? hit_start : '0;
            end
            search_reports.push_back(r);
            clear_text();
        end
        else
        begin
            for (int k = PAT_BYTES - 1; k > 0; k--)
            begin
                window_bytes[k] = window_bytes[k-1];
            end
            window_bytes[0] = b;
            text_len++;
            if (plen > 0 && text_len >= plen && !hit_seen)
            begin
                ok = 1'b1;
                for (int j = 0; j < plen; j++)
                begin
                    if (pattern_byte(j) != window_bytes[plen-1-j])
                        ok = 1'b0;
                end
                if (ok)
                begin
                    hit_seen  = 1'b1;
                    hit_start = POS_W'(text_len - plen);
                end
            end
            if (text_len >= cap)
            begin
                r.st = ST_UNTERMINATED;
                search_reports.push_back(r);
                clear_text();
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_report();
        search_report_t want;
        if (search_reports.size() == 0)
            report_mismatch($sformatf("unexpected report found=%0d pos=%0d status=%0d",
                                      found, match_position, status));
        else
        begin
            want = search_reports.pop_front();
            if (found !== want.found)
                report_mismatch($sformatf("found %0d, want %0d", found, want.found));
            if (match_position !== want.pos)
                report_mismatch($sformatf("match_position %0d, want %0d",
                                          match_position, want.pos));
            if (status !== want.st)
                report_mismatch($sformatf("status %0d, want %s", status, want.st.name()));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_valid <= 1'b0;
            text_byte  <= 8'h00;
        end
        else
        begin
            if (text_valid && !text_stall)
                scan_byte(text_byte);
            if (!text_valid || !text_stall)
            begin
                if (text_to_send.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    text_valid <= 1'b1;
                    text_byte  <= text_to_send.pop_front();
                end
                else
                    text_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
                check_report();
            result_stall <= hold_results || ($urandom_range(99) < stall_pct);
        end
    end

    task automatic write_reg(input reg_index_t idx, input logic [WORD_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PATTERN_LOW:    pat_word_lo = data;
            REG_PATTERN_HIGH:   pat_word_hi = data;
            REG_PATTERN_LENGTH: pat_len_reg = data[PLEN_W-1:0];
            REG_TEXT_CAPACITY:  cap_reg     = data[CAP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                              input logic [WORD_W-1:0] len_word,
                              input logic [WORD_W-1:0] cap_word);
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_PATTERN_LENGTH, len_word);
        write_reg(REG_TEXT_CAPACITY, cap_word);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (text_to_send.size() != 0 || text_valid || search_reports.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic queue_byte(input logic [7:0] b);
        text_to_send.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            queue_byte(s[i]);
        end
        queue_byte(8'h00);
    endtask

    task automatic random_config();
        logic [2*WORD_W-1:0] pat;
        logic [WORD_W-1:0]   len_word;
        logic [WORD_W-1:0]   cap_word;
        int                  pick;
        for (int i = 0; i < 3; i++)
        begin
            letters[i] = 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < PAT_BYTES; i++)
        begin
            pick = $urandom_range(19);
            if (pick == 0)
                pat[8*i +: 8] = 8'h00;
            else if (pick == 1)
                pat[8*i +: 8] = 8'($urandom_range(255));
            else
                pat[8*i +: 8] = letters[$urandom_range(2)];
        end
        len_word = {$urandom, $urandom};
        pick = $urandom_range(19);
        if (pick < 14)
            len_word[PLEN_W-1:0] = PLEN_W'($urandom_range(1, 4));
        else if (pick < 17)
            len_word[PLEN_W-1:0] = PLEN_W'($urandom_range(5, 16));
        else if (pick < 19)
            len_word[PLEN_W-1:0] = '0;
        else
            len_word[PLEN_W-1:0] = PLEN_W'($urandom_range(17, 31));
        cap_word = {$urandom, $urandom};
        pick = $urandom_range(19);
        if (pick < 12)
            cap_word[CAP_W-1:0] = CAP_W'($urandom_range(1, 40));
        else if (pick < 15)
            cap_word[CAP_W-1:0] = '0;
        else if (pick < 18)
            cap_word[CAP_W-1:0] = 13'd4096;
        else
            cap_word[CAP_W-1:0] = CAP_W'($urandom_range(4097, 8191));
        set_config(pat[WORD_W-1:0], pat[2*WORD_W-1:WORD_W], len_word, cap_word);
    endtask

    // Most texts carry a copy of the pattern somewhere so that matches are common.
    task automatic push_random_text();
        int len;
        int at;
        int plen;
        plen = active_plen();
        len  = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 12);
        at   = ($urandom_range(3) != 0) ? $urandom_range(0, len) : -1;
        for (int i = 0; i <= len; i++)
        begin
            if (i == at)
            begin
                for (int j = 0; j < plen; j++)
                begin
                    queue_byte(pattern_byte(j));
                end
            end
            if (i < len)
            begin
                if ($urandom_range(3) == 0)
                    queue_byte(8'($urandom_range(1, 255)));
                else
                    queue_byte(letters[$urandom_range(2)]);
            end
        end
        queue_byte(8'h00);
    endtask

    task automatic random_phase(input int n_items, input int mode);
        int start;
        random_config();
        case (mode)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 47; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 47; end
            default: begin gap_pct = 8; stall_pct = 8; end
        endcase
        start = bytes_queued;
        while (bytes_queued - start < n_items)
        begin
            push_random_text();
        end
        wait_drained();
    endtask

    initial
    begin
        for (int k = 0; k < PAT_BYTES; k++)
        begin
            window_bytes[k] = 8'h00;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_text("");
        push_text("\377\001");
        wait_drained();
        set_config(64'h0000_0000_0063_6261, 64'h0, 64'd3, 64'd4096);
        push_text("xabcabc");
        push_text("ab");
        wait_drained();
        set_config(64'h0000_0000_0000_0061, 64'h0, 64'd2, 64'd4096);
        push_text("ab");
        wait_drained();
        set_config(64'h0, 64'h0, 64'd1, 64'd0);
        queue_byte("z");
        queue_byte(8'h00);
        wait_drained();
        write_reg(REG_TEXT_CAPACITY, 64'd2);
        queue_byte(8'h80);
        queue_byte(8'h7F);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            random_phase(50, p);
        end

        set_config({56'h0, letters[0]}, 64'h0, 64'd1, 64'd4096);
        gap_pct   = 0;
        stall_pct = 0;
        fork
            begin
                hold_results = 1'b1;
                repeat (300) @(negedge clk);
                hold_results = 1'b0;
            end
        join_none
        repeat (40)
        begin
            if ($urandom_range(1) == 0)
                queue_byte(letters[0]);
            queue_byte(8'h00);
        end
        wait_drained();

        // Capacity above the maximum acts as the maximum, so longer texts still search.
        set_config(64'h0000_0000_5A59_5857, 64'h0, 64'd4, 64'h1FFF);
        gap_pct   = 8;
        stall_pct = 8;
        repeat (30) queue_byte(8'h2E);
        push_text("WXYZ");
        repeat (20) queue_byte(8'h2E);
        queue_byte(8'h00);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            random_phase(50, p);
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #800000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- first_substring_match.f -----
hdl/fsmatch_pkg.sv
hdl/fsmatch_cfg.sv
hdl/fsmatch_window_cmp.sv
hdl/first_substring_match.sv
verif/first_substring_match_tb.sv
